### rtl/assert_macros.svh
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    localparam logic [7:0] GLYPH_NEWLINE   = 8'h0A;
    localparam logic [7:0] GLYPH_BACKSPACE = 8'h08;
    localparam logic [7:0] GLYPH_SPACE     = 8'h20;
    localparam logic [7:0] COLOR_RESET     = 8'h0F;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] cell_value;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
    } t_out_item;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [15:0]       wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [15:0] make_cell(input logic [7:0] color,
                                              input logic [7:0] glyph);
        return {color, glyph};
    endfunction

endpackage

### rtl/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram (
    input  logic              i_clk,
    input  tcw_pkg::t_ram_req i_req,
    output logic [15:0]       o_rdata
);
    import tcw_pkg::*;

    logic [15:0] r_mem [CELL_COUNT];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tcw_ctrl.sv
`timescale 1ns / 1ps

module tcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tcw_pkg::t_in_item  i_item,
    input  logic [7:0]         i_color,
    input  logic [15:0]        i_rdata,
    output tcw_pkg::t_ram_req  o_ram_req,
    output logic               o_busy,
    output logic               o_valid,
    output tcw_pkg::t_out_item o_result
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK,
        ST_CLEAR
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_valid, n_valid;
    logic [15:0]       r_cell, n_cell;

    // One address adder serves every sweep: it forms the source address
    // one row ahead while scrolling and the next pointer otherwise.
    logic [ADDR_W-1:0] add_op;
    logic [ADDR_W-1:0] addr_sum;
    logic [ADDR_W-1:0] cur_idx;
    logic              last_row;
    logic              ptr_last;
    logic              idx_ok;
    logic [15:0]       blank;

    assign add_op   = (r_state == ST_SCR_RD) ? ADDR_W'(COLUMNS) : ADDR_W'(1);
    assign addr_sum = r_ptr + add_op;
    assign cur_idx  = ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
    assign last_row = (r_row == ROW_W'(ROWS - 1));
    assign ptr_last = (r_ptr == ADDR_W'(CELL_COUNT - 1));
    assign idx_ok   = (32'(i_item.cell_index) < 32'(CELL_COUNT));
    assign blank    = make_cell(i_color, GLYPH_SPACE);

    always_comb begin
        n_state         = r_state;
        n_ptr           = r_ptr;
        n_row           = r_row;
        n_col           = r_col;
        n_valid         = 1'b0;
        n_cell          = 16'h0000;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = r_ptr;
        o_ram_req.wdata = blank;
        o_ram_req.raddr = addr_sum;

        case (r_state)
            ST_INIT: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.wdata = 16'h0000;
                n_ptr           = addr_sum;
                if (ptr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_ram_req.raddr = ADDR_W'(i_item.cell_index);
                if (i_start) begin
                    case (i_item.cmd)
                        CMD_PUT: begin
                            n_valid = 1'b1;
                            if (i_item.char_code == GLYPH_BACKSPACE) begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = cur_idx - ADDR_W'(r_col != '0);
                                if (r_col != '0) begin
                                    n_col = r_col - COL_W'(1);
                                end
                            end else begin
                                if (i_item.char_code != GLYPH_NEWLINE) begin
                                    o_ram_req.we    = 1'b1;
                                    o_ram_req.waddr = cur_idx;
                                    o_ram_req.wdata = make_cell(i_color, i_item.char_code);
                                end
                                if (i_item.char_code == GLYPH_NEWLINE ||
                                    r_col == COL_W'(COLUMNS - 1)) begin
                                    n_col = '0;
                                    if (last_row) begin
                                        // Bottom row reached: scroll before reporting.
                                        n_valid = 1'b0;
                                        n_ptr   = '0;
                                        n_state = ST_SCR_RD;
                                    end else begin
                                        n_row = r_row + ROW_W'(1);
                                    end
                                end else begin
                                    n_col = r_col + COL_W'(1);
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            n_row   = '0;
                            n_col   = '0;
                            n_ptr   = '0;
                            n_state = ST_CLEAR;
                        end
                        CMD_READ: begin
                            if (idx_ok) begin
                                n_state = ST_READ;
                            end else begin
                                n_valid = 1'b1;
                            end
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_valid = 1'b1;
                n_cell  = i_rdata;
                n_state = ST_IDLE;
            end
            ST_SCR_RD: begin
                n_state = ST_SCR_WR;
            end
            ST_SCR_WR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.wdata = i_rdata;
                n_ptr           = addr_sum;
                if (r_ptr == ADDR_W'(CELL_COUNT - COLUMNS - 1)) begin
                    n_state = ST_BLANK;
                end else begin
                    n_state = ST_SCR_RD;
                end
            end
            ST_BLANK, ST_CLEAR: begin
                o_ram_req.we = 1'b1;
                n_ptr        = addr_sum;
                if (ptr_last) begin
                    n_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_ptr   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_row   <= n_row;
            r_col   <= n_col;
            r_valid <= n_valid;
        end
        r_cell <= n_cell;
    end

    assign o_busy              = (r_state != ST_IDLE);
    assign o_valid             = r_valid;
    assign o_result.cell_value = r_cell;
    assign o_result.cursor_row = 5'(r_row);
    assign o_result.cursor_col = 7'(r_col);

endmodule

### rtl/text_console_writer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Handshake                Payload
// command   start, busy              i_item (cmd, char_code, cell_index)
// result    o_valid (one cycle)      o_result (cell_value, cursor_row, cursor_col)
// config    i_cfg_we                 i_cfg_data (text color)
//
// A plain put, newline or backspace reports from the idle state, as do a read out of range
// and the unused command; a read of a stored cell first passes through the read state.
// A put that moves past the last row scrolls the store: each cell below the top row is
// read and written one row up, and then the last row is blanked with the text color.
// Clear fills the store with blanks and homes the cursor; after reset a like sweep
// writes zeroes, and busy stays high until it ends. The result strobe lasts one cycle
// and cannot be held off.

module text_console_writer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  tcw_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_data,
    output logic               o_valid,
    output tcw_pkg::t_out_item o_result
);
    import tcw_pkg::*;

    logic [7:0]  r_text_color;
    t_ram_req    ram_req;
    logic [15:0] ram_rdata;
    logic        cursor_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= COLOR_RESET;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_data;
        end
    end

    tcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_item    (i_item),
        .i_color   (r_text_color),
        .i_rdata   (ram_rdata),
        .o_ram_req (ram_req),
        .o_busy    (busy),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    tcw_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (ram_rdata)
    );

    assign cursor_ok = (32'(o_result.cursor_row) < 32'(ROWS)) &&
                       (32'(o_result.cursor_col) < 32'(COLUMNS));

    // A result is only reported once the sequencer is back at rest.
    `ASSERT_SAME(a_valid_not_busy, i_clk, i_rst_n, o_valid, !busy)
    `ASSERT_SAME(a_cursor_range, i_clk, i_rst_n, o_valid, cursor_ok)
    `ASSERT_NEXT(a_clear_sweeps, i_clk, i_rst_n, start && !busy && (i_item.cmd == CMD_CLEAR), busy && !o_valid)

endmodule
